// ===== rtl/rx_descriptor_ring_frame_fetch_core_defines.svh =====
// Assertion macros used by the checker file of the receive ring core.
`ifndef RX_DESCRIPTOR_RING_FRAME_FETCH_CORE_DEFINES_SVH
`define RX_DESCRIPTOR_RING_FRAME_FETCH_CORE_DEFINES_SVH

// Clocked assertion with an explicit disable condition.
`define RDF_ASSERT(lbl, clk, dis, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (prop)) else $error(msg);

// Clocked assertion that is off while the active-low reset is asserted.
`define RDF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  `RDF_ASSERT(lbl, clk, !(rst_n), prop, msg)

`endif

// ===== rtl/rdf_pkg.sv =====
`timescale 1ns / 1ps

package rdf_pkg;

  // Ring geometry
  localparam int RING_SLOTS = 32;
  localparam int SLOT_BYTES = 128;

  // Derived widths
  localparam int PTR_W   = $clog2(RING_SLOTS);
  localparam int CNT_W   = $clog2(RING_SLOTS + 1);
  localparam int CHUNK_W = $clog2(RING_SLOTS * SLOT_BYTES + 1);

  // Field widths of the words
  localparam int SLOT_W  = 5;
  localparam int LEN_W   = 11;
  localparam int FIRST_W = 12;
  localparam int REL_W   = 6;

  // Saturation limits of the result word
  localparam int FIRST_MAX = 4095;
  localparam int REL_MAX   = 63;

  // Request codes
  localparam logic MODE_FILL  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  // Descriptor status as kept in the status RAM
  typedef struct packed {
    logic             eof;
    logic             sof;
    logic [LEN_W-1:0] len;
  } slot_status_t;

  localparam int STATUS_W = $bits(slot_status_t);

  // One evaluated walk step
  typedef struct packed {
    logic [PTR_W-1:0] ptr_inc;
    logic [CNT_W-1:0] n_inc;
    logic             n_live;
    logic             owned;
    logic             sof;
    logic             eof;
    logic [LEN_W-1:0] len;
    logic             len_nz;
    logic             walk_on;
    logic             last;
  } step_t;

  // Chunk split of a found frame
  typedef struct packed {
    logic               wrap;
    logic [FIRST_W-1:0] first;
    logic [LEN_W-1:0]   second;
  } chunk_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SKIP_RD,
    ST_SKIP_EV,
    ST_SRCH_RD,
    ST_SRCH_EV,
    ST_TRUNC_GO,
    ST_TRUNC_RD,
    ST_TRUNC_EV,
    ST_CHUNK,
    ST_REL_RD,
    ST_REL_EV,
    ST_DONE
  } fsm_t;

endpackage

// ===== rtl/rdf_if.sv =====
`timescale 1ns / 1ps

// Request channel: fill or fetch word
interface rdf_in_if;
  import rdf_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [SLOT_W-1:0] slot;
  logic              start_of_frame;
  logic              end_of_frame;
  logic [LEN_W-1:0]  frame_length;

  modport source (
    output valid, mode, slot, start_of_frame, end_of_frame, frame_length,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, start_of_frame, end_of_frame, frame_length,
    output ready
  );
endinterface

// Result channel: one word per fetch
interface rdf_out_if;
  import rdf_pkg::*;

  logic               valid;
  logic               ready;
  logic               frame_found;
  logic [SLOT_W-1:0]  first_slot;
  logic [FIRST_W-1:0] first_length;
  logic               wrapped;
  logic [LEN_W-1:0]   second_length;
  logic [REL_W-1:0]   slots_released;

  modport source (
    output valid, frame_found, first_slot, first_length, wrapped, second_length,
           slots_released,
    input  ready
  );
  modport sink (
    input  valid, frame_found, first_slot, first_length, wrapped, second_length,
           slots_released,
    output ready
  );
endinterface

// ===== rtl/rdf_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one registered read port.
module rdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rdf_step_unit.sv =====
`timescale 1ns / 1ps

// Shared walk step: pointer advance, step count and slot tests.
module rdf_step_unit (
  input  logic [rdf_pkg::PTR_W-1:0] ptr,
  input  logic [rdf_pkg::CNT_W-1:0] n,
  input  logic                      owned,
  input  rdf_pkg::slot_status_t     status,
  output rdf_pkg::step_t            step
);
  import rdf_pkg::*;

  always_comb begin
    step.ptr_inc = (ptr == PTR_W'(RING_SLOTS - 1)) ? '0 : ptr + PTR_W'(1);
    step.n_inc   = n + CNT_W'(1);
    step.n_live  = (n < CNT_W'(RING_SLOTS));
    step.owned   = owned;
    step.sof     = status.sof;
    step.eof     = status.eof;
    step.len     = status.len;
    step.len_nz  = (status.len != '0);
    // keep walking while the slot is owned and is not a frame start
    step.walk_on = step.n_live && owned && !status.sof;
    step.last    = (step.n_inc == CNT_W'(RING_SLOTS));
  end

endmodule

// ===== rtl/rdf_chunk_calc.sv =====
`timescale 1ns / 1ps

// Splits a found frame into the chunk up to ring end and the chunk at ring start.
module rdf_chunk_calc (
  input  logic [rdf_pkg::PTR_W-1:0] start_ptr,
  input  logic [rdf_pkg::PTR_W-1:0] len_ptr,
  input  logic [rdf_pkg::LEN_W-1:0] flen,
  output rdf_pkg::chunk_t           chunk
);
  import rdf_pkg::*;

  logic [CHUNK_W-1:0] tail_bytes;

  // bytes from the start slot to the ring end
  assign tail_bytes = CHUNK_W'((RING_SLOTS - 32'(start_ptr)) * SLOT_BYTES);

  always_comb begin
    chunk.wrap = (len_ptr < start_ptr);
    if (chunk.wrap) begin
      chunk.first  = (32'(tail_bytes) > FIRST_MAX) ? FIRST_W'(FIRST_MAX)
                                                   : FIRST_W'(tail_bytes);
      chunk.second = (32'(flen) > 32'(tail_bytes))
                   ? LEN_W'(32'(flen) - 32'(tail_bytes)) : '0;
    end else begin
      chunk.first  = FIRST_W'(flen);
      chunk.second = '0;
    end
  end

endmodule

// ===== rtl/rx_descriptor_ring_frame_fetch_core.sv =====
// Receive descriptor ring, frame fetch.
// in_ch carries fill and fetch words. A fill word (mode 0) marks one slot owned
// and stores its start, end and length flags; it is taken while idle and
// gives no result. A fetch word (mode 1) releases owned slots up to the next
// frame start, searches for the slot that holds the frame length, drops a
// truncated frame, and releases the slots of a found frame up to its end flag.
// Each fetch gives one word on out_ch with the start slot, one or two chunk
// lengths and the count of released slots.
// Every walk step is one status RAM read plus one pass through the shared step
// unit. The result word is loaded once the skip, search, truncation drop and
// release walks are done, and in_ch.ready is low while a fetch runs; the next
// word is taken when the core is back in idle.
// A finished result sits in the output register; fills are taken while it
// waits, and a following fetch holds in its last state until out_ch takes it.
// Reset (rst_n low, synchronous) clears the owned flags, the read pointer and
// the handshake state; the status RAM is not cleared.
`timescale 1ns / 1ps

module rx_descriptor_ring_frame_fetch_core (
  input  logic  clk,
  input  logic  rst_n,
  rdf_in_if.sink    in_ch,
  rdf_out_if.source out_ch
);
  import rdf_pkg::*;

  fsm_t state_r, state_nxt;

  logic [RING_SLOTS-1:0] owned_r, owned_nxt;
  logic [PTR_W-1:0]      rp_r, rp_nxt;
  logic [PTR_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [LEN_W-1:0]      flen_r, flen_nxt;
  logic [PTR_W-1:0]      start_r, start_nxt;
  logic                  found_r, found_nxt;
  chunk_t                chunk_r, chunk_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [FIRST_W-1:0]    out_first_r;
  logic                  out_wrap_r;
  logic [LEN_W-1:0]      out_second_r;
  logic [REL_W-1:0]      out_rel_r;
  logic                  out_load;

  logic                  in_acc, fill_acc, fetch_acc, slot_ok;
  logic [PTR_W-1:0]      walk_ptr;
  slot_status_t          wr_status, rd_status;
  step_t                 step;
  chunk_t                chunk;
  logic                  rel_en;

  // Request decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_ok     = (32'(in_ch.slot) < RING_SLOTS);
  assign fill_acc    = in_acc && (in_ch.mode == MODE_FILL) && slot_ok;
  assign fetch_acc   = in_acc && (in_ch.mode == MODE_FETCH);

  assign wr_status.eof = in_ch.end_of_frame;
  assign wr_status.sof = in_ch.start_of_frame;
  assign wr_status.len = in_ch.frame_length;

  // Search walks its own pointer, all other walks move the read pointer
  assign walk_ptr = (state_r == ST_SRCH_RD || state_r == ST_SRCH_EV) ? i_r : rp_r;

  rdf_ram #(
    .WIDTH (STATUS_W),
    .DEPTH (RING_SLOTS)
  ) u_status_ram (
    .clk   (clk),
    .we    (fill_acc),
    .waddr (PTR_W'(in_ch.slot)),
    .wdata (wr_status),
    .raddr (walk_ptr),
    .rdata (rd_status)
  );

  rdf_step_unit u_step (
    .ptr    (walk_ptr),
    .n      (n_r),
    .owned  (owned_r[walk_ptr]),
    .status (rd_status),
    .step   (step)
  );

  rdf_chunk_calc u_chunk (
    .start_ptr (rp_r),
    .len_ptr   (i_r),
    .flen      (flen_r),
    .chunk     (chunk)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (fetch_acc) state_nxt = ST_SKIP_RD;
      ST_SKIP_RD:  state_nxt = ST_SKIP_EV;
      ST_SKIP_EV:  state_nxt = step.walk_on ? ST_SKIP_RD : ST_SRCH_RD;
      ST_SRCH_RD:  state_nxt = ST_SRCH_EV;
      ST_SRCH_EV: begin
        if (step.n_live && step.owned) begin
          if ((i_r != rp_r) && step.sof) state_nxt = ST_TRUNC_GO;
          else if (step.len_nz)          state_nxt = ST_CHUNK;
          else                           state_nxt = ST_SRCH_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_TRUNC_GO: state_nxt = ST_TRUNC_RD;
      ST_TRUNC_RD: state_nxt = ST_TRUNC_EV;
      ST_TRUNC_EV: state_nxt = step.walk_on ? ST_TRUNC_RD : ST_DONE;
      ST_CHUNK:    state_nxt = ST_REL_RD;
      ST_REL_RD:   state_nxt = ST_REL_EV;
      ST_REL_EV:   state_nxt = (step.eof || step.last) ? ST_DONE : ST_REL_RD;
      ST_DONE:     if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and control outputs
  always_comb begin
    owned_nxt = owned_r;
    rp_nxt    = rp_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    count_nxt = count_r;
    flen_nxt  = flen_r;
    start_nxt = start_r;
    found_nxt = found_r;
    chunk_nxt = chunk_r;
    rel_en    = 1'b0;
    out_load  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (fill_acc) begin
          owned_nxt[PTR_W'(in_ch.slot)] = 1'b1;
        end
        if (fetch_acc) begin
          n_nxt     = '0;
          count_nxt = '0;
          found_nxt = 1'b0;
          chunk_nxt = '0;
          start_nxt = '0;
        end
      end
      ST_SKIP_EV: begin
        if (step.walk_on) begin
          rel_en = 1'b1;
          n_nxt  = step.n_inc;
        end else begin
          i_nxt = rp_r;
          n_nxt = '0;
        end
      end
      ST_SRCH_EV: begin
        if (step.n_live && step.owned) begin
          if ((i_r != rp_r) && step.sof) begin
            n_nxt = '0;
          end else if (step.len_nz) begin
            flen_nxt = step.len;
          end else begin
            i_nxt = step.ptr_inc;
            n_nxt = step.n_inc;
          end
        end
      end
      // first pass of the drop walk releases the start slot unconditionally
      ST_TRUNC_GO: begin
        rel_en = 1'b1;
        n_nxt  = CNT_W'(1);
      end
      ST_TRUNC_EV: begin
        if (step.walk_on) begin
          rel_en = 1'b1;
          n_nxt  = step.n_inc;
        end
      end
      ST_CHUNK: begin
        found_nxt = 1'b1;
        start_nxt = rp_r;
        chunk_nxt = chunk;
        n_nxt     = '0;
      end
      ST_REL_EV: begin
        rel_en = 1'b1;
        n_nxt  = step.n_inc;
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase

    // release the slot under the read pointer and advance it
    if (rel_en) begin
      owned_nxt[rp_r] = 1'b0;
      count_nxt       = count_r + CNT_W'(owned_r[rp_r]);
      rp_nxt          = step.ptr_inc;
    end
  end

  // Output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load)                    out_valid_nxt = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      owned_r     <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      owned_r     <= owned_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    count_r <= count_nxt;
    flen_r  <= flen_nxt;
    start_r <= start_nxt;
    found_r <= found_nxt;
    chunk_r <= chunk_nxt;
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r  <= found_r;
      out_slot_r   <= SLOT_W'(start_r);
      out_first_r  <= chunk_r.first;
      out_wrap_r   <= chunk_r.wrap;
      out_second_r <= chunk_r.second;
      out_rel_r    <= (32'(count_r) > REL_MAX) ? REL_W'(REL_MAX) : REL_W'(count_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_found    = out_found_r;
  assign out_ch.first_slot     = out_slot_r;
  assign out_ch.first_length   = out_first_r;
  assign out_ch.wrapped        = out_wrap_r;
  assign out_ch.second_length  = out_second_r;
  assign out_ch.slots_released = out_rel_r;

endmodule

// ===== rtl/rdf_checker.sv =====
`timescale 1ns / 1ps
`include "rx_descriptor_ring_frame_fetch_core_defines.svh"

// Port-level checks of the receive ring core.
module rdf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_mode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_frame_found,
  input logic [rdf_pkg::SLOT_W-1:0]  out_first_slot,
  input logic [rdf_pkg::FIRST_W-1:0] out_first_length,
  input logic                        out_wrapped,
  input logic [rdf_pkg::LEN_W-1:0]   out_second_length,
  input logic [rdf_pkg::REL_W-1:0]   out_slots_released
);
  import rdf_pkg::*;

  // a result word is not dropped while the receiver stalls
  `RDF_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result word dropped")

  // a fetch keeps the request channel busy in the next cycle
  `RDF_ASSERT_RST(a_fetch_busy, clk, rst_n, in_valid && in_ready && (in_mode == MODE_FETCH) |=> !in_ready, "ready after fetch")

  // no frame means all frame fields are zero
  `RDF_ASSERT_RST(a_no_frame, clk, rst_n, out_valid && !out_frame_found |-> (out_first_slot == '0) && (out_first_length == '0) && !out_wrapped && (out_second_length == '0), "frame fields set without frame")

  // a second chunk exists only for a wrapped frame
  `RDF_ASSERT_RST(a_second_wrap, clk, rst_n, out_valid && !out_wrapped |-> (out_second_length == '0), "second length without wrap")

  // no fetch returns more slots than the ring holds
  `RDF_ASSERT_RST(a_rel_bound, clk, rst_n, out_valid |-> (32'(out_slots_released) <= RING_SLOTS), "too many slots released")

endmodule

bind rx_descriptor_ring_frame_fetch_core rdf_checker u_rdf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_mode            (in_ch.mode),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_frame_found    (out_ch.frame_found),
  .out_first_slot     (out_ch.first_slot),
  .out_first_length   (out_ch.first_length),
  .out_wrapped        (out_ch.wrapped),
  .out_second_length  (out_ch.second_length),
  .out_slots_released (out_ch.slots_released)
);

// ===== tb/rx_ring_fetch_scoreboard.sv =====
`timescale 1ns / 1ps

module rx_ring_fetch_scoreboard (
  input  logic      clk,
  input  logic      rst_n,
  rdf_in_if         in_mon,
  rdf_out_if        out_mon,
  output int        fail_count,
  output int        pending,
  output int        n_checked,
  output int        n_found,
  output int        n_wrapped
);
  import rdf_pkg::*;

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  first_slot;
    logic [FIRST_W-1:0] first_len;
    logic               wrapped;
    logic [LEN_W-1:0]   second_len;
    logic [REL_W-1:0]   released;
  } fetch_report_t;

  // shadow copy of the ring
  bit           ring_owned [RING_SLOTS];
  slot_status_t ring_stat  [RING_SLOTS];
  int           ring_rd;

  fetch_report_t reports_due[$];
  fetch_report_t got, want;

  function automatic int ring_step(int p);
    return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
  endfunction

  // hand one descriptor back to the receiver if it is still owned
  function automatic int give_back(int p);
    if (ring_owned[p]) begin
      ring_owned[p] = 1'b0;
      return 1;
    end
    return 0;
  endfunction

  // one fetch: skip stale slots, search for the length slot, drop a
  // truncated frame, split a found frame into chunks and release it
  function automatic fetch_report_t fetch_frame();
    int unsigned rp, i, j, n, m, cnt, flen, start, first, second;
    bit wrap;
    fetch_report_t r;
    rp = ring_rd;
    cnt = 0;
    flen = 0;
    first = 0;
    second = 0;
    wrap = 1'b0;

    // release leftovers up to the next frame start
    n = 0;
    while (n < RING_SLOTS && ring_owned[rp] && !ring_stat[rp].sof) begin
      cnt += give_back(rp);
      rp = ring_step(rp);
      n++;
    end

    // search for the slot carrying the frame length
    i = rp;
    for (n = 0; n < RING_SLOTS && ring_owned[i]; n++) begin
      if (i != rp && ring_stat[i].sof) begin
        // truncated frame: drop it up to the next start
        cnt += give_back(rp);
        rp = ring_step(rp);
        m = 1;
        while (m < RING_SLOTS && ring_owned[rp] && !ring_stat[rp].sof) begin
          cnt += give_back(rp);
          rp = ring_step(rp);
          m++;
        end
        break;
      end
      flen = 32'(ring_stat[i].len);
      if (flen != 0) break;
      i = ring_step(i);
    end

    start = rp;
    if (flen != 0) begin
      if (i < rp) begin
        wrap = 1'b1;
        first = (RING_SLOTS - rp) * SLOT_BYTES;
        second = (flen > first) ? flen - first : 0;
      end else begin
        first = flen;
      end
      // release the frame up to its end flag, at most one lap
      for (n = 0; n < RING_SLOTS; n++) begin
        j = rp;
        cnt += give_back(rp);
        rp = ring_step(rp);
        if (ring_stat[j].eof) break;
      end
    end
    ring_rd = rp;

    if (first > FIRST_MAX) first = FIRST_MAX;
    if (cnt > REL_MAX) cnt = REL_MAX;

    r.found      = (flen != 0);
    r.first_slot = (flen != 0) ? start[SLOT_W-1:0] : '0;
    r.first_len  = first[FIRST_W-1:0];
    r.wrapped    = wrap;
    r.second_len = second[LEN_W-1:0];
    r.released   = cnt[REL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < RING_SLOTS; s++) ring_owned[s] = 1'b0;
      ring_rd = 0;
      reports_due.delete();
      pending = 0;
    end else begin
      // result side: compare with the oldest expected report
      if (out_mon.valid && out_mon.ready) begin
        got.found      = out_mon.frame_found;
        got.first_slot = out_mon.first_slot;
        got.first_len  = out_mon.first_length;
        got.wrapped    = out_mon.wrapped;
        got.second_len = out_mon.second_length;
        got.released   = out_mon.slots_released;
        if (reports_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with no fetch pending: found=%0d slot=%0d",
                     $realtime, got.found, got.first_slot);
        end else begin
          want = reports_due.pop_front();
          n_checked++;
          if (want.found) n_found++;
          if (want.wrapped) n_wrapped++;
          if (got.found !== want.found || got.first_slot !== want.first_slot ||
              got.first_len !== want.first_len || got.wrapped !== want.wrapped ||
              got.second_len !== want.second_len || got.released !== want.released) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: fetch result %0d mismatch", $realtime, n_checked);
              $display("  expected found=%0d slot=%0d first=%0d wrap=%0d second=%0d rel=%0d",
                       want.found, want.first_slot, want.first_len, want.wrapped,
                       want.second_len, want.released);
              $display("  actual   found=%0d slot=%0d first=%0d wrap=%0d second=%0d rel=%0d",
                       got.found, got.first_slot, got.first_len, got.wrapped,
                       got.second_len, got.released);
            end
          end
        end
      end

      // request side: fills update the ring, fetches predict a report
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode == MODE_FETCH) begin
          reports_due.push_back(fetch_frame());
        end else begin
          ring_owned[in_mon.slot]     = 1'b1;
          ring_stat[in_mon.slot].len  = in_mon.frame_length;
          ring_stat[in_mon.slot].sof  = in_mon.start_of_frame;
          ring_stat[in_mon.slot].eof  = in_mon.end_of_frame;
        end
      end
      pending = reports_due.size();
    end
  end

endmodule

// ===== tb/tb_rx_descriptor_ring_frame_fetch_core.sv =====
`timescale 1ns / 1ps

module tb_rx_descriptor_ring_frame_fetch_core;
  import rdf_pkg::*;

  localparam int N_WORDS      = 1000;
  localparam int TAIL_AT      = 850;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LEN_MAX      = (1 << LEN_W) - 1;

  logic clk = 1'b0;
  logic rst_n;

  rdf_in_if  in_ch ();
  rdf_out_if out_ch ();

  int  fail_count, pending, n_checked, n_found, n_wrapped;
  int  words_sent, words_fill, words_fetch;
  int  wr_ptr;
  int  cycles;
  bit  quiet_tail;
  bit  calm;

  // quiet stretches mid run, and a wholly quiet tail
  assign calm = quiet_tail || ((words_sent / 64) % 4 == 3);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_descriptor_ring_frame_fetch_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rx_ring_fetch_scoreboard u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_found    (n_found),
    .n_wrapped  (n_wrapped)
  );

  // offer one word, with an occasional idle burst in front of it
  task automatic send_word(input logic mode, input logic [SLOT_W-1:0] slot,
                           input logic sof, input logic eof,
                           input logic [LEN_W-1:0] flen);
    int idle;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      idle = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= mode;
    in_ch.slot           <= slot;
    in_ch.start_of_frame <= sof;
    in_ch.end_of_frame   <= eof;
    in_ch.frame_length   <= flen;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    words_sent++;
    if (mode == MODE_FETCH) words_fetch++;
    else words_fill++;
  endtask

  // fetch words carry junk in the fill-only fields
  task automatic send_fetch();
    send_word(MODE_FETCH, SLOT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, LEN_MAX)));
  endtask

  // write a frame of consecutive slots at the receiver's write position
  task automatic put_frame(input int nslots, input bit with_end, input bit with_len,
                           input logic [LEN_W-1:0] flen);
    bit last;
    for (int s = 0; s < nslots; s++) begin
      last = (s == nslots - 1);
      send_word(MODE_FILL, wr_ptr[SLOT_W-1:0], s == 0, last && with_end,
                (last && with_len) ? flen : '0);
      wr_ptr = (wr_ptr + 1) % RING_SLOTS;
    end
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure, with one long hold mid run
  initial begin
    bit held;
    int idle;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && words_sent >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        idle = $urandom_range(1, 4);
        out_ch.ready <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int pick, k, lo, hi;
    logic [LEN_W-1:0] flen;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_FILL;
    in_ch.slot           = '0;
    in_ch.start_of_frame = 1'b0;
    in_ch.end_of_frame   = 1'b0;
    in_ch.frame_length   = '0;
    quiet_tail           = 1'b0;
    wr_ptr               = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fetch on an empty ring: nothing found, nothing released
    send_fetch();
    // write every slot once with stale buffers; only slot 29 carries an end flag
    for (int s = 0; s < RING_SLOTS; s++)
      send_word(MODE_FILL, SLOT_W'(s), 1'b0, s == 29, '0);
    // no start anywhere: the skip walk gives back the whole ring
    send_fetch();
    // plain three-slot frame
    send_word(MODE_FILL, SLOT_W'(0), 1'b1, 1'b0, '0);
    send_word(MODE_FILL, SLOT_W'(1), 1'b0, 1'b0, '0);
    send_word(MODE_FILL, SLOT_W'(2), 1'b0, 1'b1, 11'd300);
    send_fetch();
    // single-slot frame of maximum length
    send_word(MODE_FILL, SLOT_W'(3), 1'b1, 1'b1, LEN_W'(LEN_MAX));
    send_fetch();
    // truncated frame at 4 dropped, then the frame at 5 delivered
    send_word(MODE_FILL, SLOT_W'(4), 1'b1, 1'b0, '0);
    send_word(MODE_FILL, SLOT_W'(5), 1'b1, 1'b0, '0);
    send_word(MODE_FILL, SLOT_W'(6), 1'b0, 1'b1, 11'd100);
    send_fetch();
    send_fetch();
    // leftover buffer in front of a one-byte frame
    send_word(MODE_FILL, SLOT_W'(7), 1'b0, 1'b0, '0);
    send_word(MODE_FILL, SLOT_W'(8), 1'b1, 1'b1, 11'd1);
    send_fetch();
    // length slot without end flag: release runs over free slots to slot 29
    send_word(MODE_FILL, SLOT_W'(9), 1'b1, 1'b0, 11'd50);
    send_fetch();
    // frame wraps past the ring end, second chunk clamps to zero
    send_word(MODE_FILL, SLOT_W'(30), 1'b1, 1'b0, '0);
    send_word(MODE_FILL, SLOT_W'(31), 1'b0, 1'b0, '0);
    send_word(MODE_FILL, SLOT_W'(0), 1'b0, 1'b1, 11'd200);
    send_fetch();
    wr_ptr = 1;

    // random traffic, mostly well-formed frames
    while (words_sent < N_WORDS) begin
      if (words_sent >= TAIL_AT) quiet_tail = 1'b1;
      pick = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) begin
        flen = LEN_W'($urandom_range(1, LEN_MAX));
      end else begin
        hi = k * SLOT_BYTES;
        if (hi > LEN_MAX) hi = LEN_MAX;
        lo = (k - 1) * SLOT_BYTES + 1;
        if (lo > hi) lo = hi;
        flen = LEN_W'($urandom_range(lo, hi));
      end
      if (pick < 44) begin
        put_frame(k, 1'b1, 1'b1, flen);
      end else if (pick < 82) begin
        send_fetch();
      end else if (pick < 90) begin
        // stray fill anywhere in the ring
        send_word(MODE_FILL, SLOT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)),
                  $urandom_range(0, 1) ? LEN_W'($urandom_range(1, LEN_MAX)) : '0);
      end else if (pick < 96) begin
        // frame cut off before its length slot
        put_frame(k, 1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (pick < 99) begin
        // length slot that lacks the end flag
        put_frame(k, 1'b0, 1'b1, flen);
      end else begin
        // whole ring in one frame with no end flag, length maybe missing
        put_frame(RING_SLOTS, 1'b0, 1'($urandom_range(0, 1)), flen);
        send_fetch();
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d fill and %0d fetch words; %0d fetch results checked",
             words_fill, words_fetch, n_checked);
    $display("%0d frames delivered, %0d of them wrapped; %0d failures",
             n_found, n_wrapped, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rdf_pkg.sv
rtl/rdf_if.sv
rtl/rdf_ram.sv
rtl/rdf_step_unit.sv
rtl/rdf_chunk_calc.sv
rtl/rx_descriptor_ring_frame_fetch_core.sv
rtl/rdf_checker.sv
tb/rx_ring_fetch_scoreboard.sv
tb/tb_rx_descriptor_ring_frame_fetch_core.sv
